// ===== rtl/core/iir6_pkg.sv =====
// Package for the sixth-order direct-form-I IIR unit: widths and coefficient tables.
package iir6_pkg;

  localparam int DEF_FILTER_ORDER   = 6;
  localparam int DEF_COEF_FRAC_BITS = 14;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 24;
  localparam int Y_FRAC   = 8;
  localparam int DIGIT_W  = 8;
  localparam int DIGITS   = WORD_W / DIGIT_W;
  localparam int DIG_CW   = $clog2(DIGITS);
  localparam int TAB_LEN  = 17;

  localparam int NUM_TENK [TAB_LEN] = '{
    1085, 0, -3255, 0, 3255, 0, -1085, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };
  localparam int DEN_TENK [TAB_LEN] = '{
    10000, -11355, 9443, -6378, 5444, -1737, 459, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // round half away from zero to frac fraction bits
  function automatic longint to_fixed(input int tenk, input int frac);
    longint scale;
    longint mag;
    scale = longint'(1) << frac;
    mag   = (tenk >= 0) ? longint'(tenk) : -longint'(tenk);
    mag   = (mag * scale + 64'sd5000) / 64'sd10000;
    return (tenk >= 0) ? mag : -mag;
  endfunction

  // tap 0..order: b_k on x; tap order+1..2*order: -a_k on y
  function automatic longint tap_coef(input int tap, input int order, input int frac);
    int k;
    longint c;
    c = 0;
    if (tap <= order) begin
      k = tap;
      if (k < TAB_LEN) c = to_fixed(NUM_TENK[k], frac);
    end else begin
      k = tap - order;
      if (k < TAB_LEN) c = -to_fixed(DEN_TENK[k], frac);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/iir_direct_form_one_order6_unit.sv =====
// Sixth-order direct-form-I IIR filter with a digit-serial multiply-accumulate.
//
// Input channel: sample_in with in_valid/in_ready; a transfer happens when both are high.
// Output channel: sample_out with out_valid/out_ready, held in an output register.
// One item is in work at a time. in_ready is high only while the unit is idle; it
// stays high while a finished result still waits in the output register.
// Work: the 2*FILTER_ORDER+1 history words (input x[n-k] scaled by 256, output y[n-k]
// in Q16.8) sit in one circular shift register that moves one 8-bit digit per cycle.
// Each cycle one coefficient times one digit is added into the accumulator; after the
// MAC loop has run over every digit of every tap, one state rounds the sum to Q16.8 and
// the next rounds it to 16 bits and loads the output register.
// If the receiver stalls, the finished item waits in the last state until the output
// register is free; histories are updated when the result is loaded.
// Reset (rst, synchronous) clears both histories to zero and empties the output.
module iir_direct_form_one_order6_unit
  import iir6_pkg::*;
#(
  parameter int FILTER_ORDER   = DEF_FILTER_ORDER,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int NTAP   = 2 * FILTER_ORDER + 1;
  localparam int TAP_W  = $clog2(NTAP);
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + DIGIT_W + 1;
  localparam int ACC_W  = COEF_W + WORD_W + $clog2(NTAP + 1);
  localparam int CH_W   = NTAP * WORD_W;
  localparam int YBASE  = FILTER_ORDER + 1;
  localparam logic [TAP_W-1:0]  TAP_LAST = TAP_W'(NTAP - 1);
  localparam logic [DIG_CW-1:0] DIG_LAST = DIG_CW'(DIGITS - 1);
  localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_HI  = ACC_W'((64'sd1 <<< (WORD_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_LO  = -Y_HI - ACC_W'(1);
  localparam logic signed [WORD_W:0]  RND_O = (WORD_W + 1)'(1 << (Y_FRAC - 1));
  localparam logic signed [WORD_W:0]  O_HI  = (WORD_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [WORD_W:0]  O_LO  = -O_HI - (WORD_W + 1)'(1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ROUND, S_OUT} state_t;

  state_t                    state;
  logic [CH_W-1:0]           chain;
  logic [CH_W-1:0]           chain_shift;
  logic [TAP_W-1:0]          tap;
  logic [DIG_CW-1:0]         dig;
  logic signed [ACC_W-1:0]   acc;
  logic signed [WORD_W-1:0]  ynew;
  logic signed [COEF_W-1:0]  coef_tab [NTAP];
  logic signed [COEF_W-1:0]  coef_cur;
  logic signed [DIGIT_W:0]   digit_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [WORD_W-1:0]  y_sat;
  logic signed [WORD_W:0]    o_rnd;
  logic signed [WORD_W:0]    o_sh;
  logic signed [SAMPLE_W-1:0] o_sat;
  logic                      out_free;

  for (genvar g = 0; g < NTAP; g++) begin : g_coef
    assign coef_tab[g] = COEF_W'(tap_coef(g, FILTER_ORDER, COEF_FRAC_BITS));
  end

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // digit MAC: low digits unsigned, top digit carries the sign
  always_comb begin
    coef_cur = coef_tab[tap];
    if (dig == DIG_LAST) digit_s = {chain[DIGIT_W-1], chain[DIGIT_W-1:0]};
    else                 digit_s = {1'b0, chain[DIGIT_W-1:0]};
    prod = coef_cur * digit_s;
    term = ACC_W'(prod) <<< (dig * DIGIT_W);
  end

  always_comb begin
    acc_rnd = acc + RND_Y;
    acc_sh  = acc_rnd >>> COEF_FRAC_BITS;
    if (acc_sh > Y_HI)      y_sat = Y_HI[WORD_W-1:0];
    else if (acc_sh < Y_LO) y_sat = Y_LO[WORD_W-1:0];
    else                    y_sat = acc_sh[WORD_W-1:0];
  end

  always_comb begin
    o_rnd = {ynew[WORD_W-1], ynew} + RND_O;
    o_sh  = o_rnd >>> Y_FRAC;
    if (o_sh > O_HI)      o_sat = O_HI[SAMPLE_W-1:0];
    else if (o_sh < O_LO) o_sat = O_LO[SAMPLE_W-1:0];
    else                  o_sat = o_sh[SAMPLE_W-1:0];
  end

  // history shift: x0 moves into the input line, ynew into the output line
  always_comb begin
    chain_shift = chain;
    for (int i = FILTER_ORDER; i >= 2; i--) begin
      chain_shift[i*WORD_W +: WORD_W] = chain[(i-1)*WORD_W +: WORD_W];
      chain_shift[(YBASE+i-1)*WORD_W +: WORD_W] = chain[(YBASE+i-2)*WORD_W +: WORD_W];
    end
    chain_shift[WORD_W +: WORD_W]       = chain[0 +: WORD_W];
    chain_shift[YBASE*WORD_W +: WORD_W] = ynew;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chain     <= '0;
      tap       <= '0;
      dig       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_OUT && out_free) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            chain[0 +: WORD_W] <= {sample_in, {Y_FRAC{1'b0}}};
            tap   <= '0;
            dig   <= '0;
            acc   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          acc   <= acc + term;
          chain <= {chain[DIGIT_W-1:0], chain[CH_W-1:DIGIT_W]};
          if (dig == DIG_LAST) begin
            dig <= '0;
            if (tap == TAP_LAST) state <= S_ROUND;
            else                 tap   <= tap + TAP_W'(1);
          end else begin
            dig <= dig + DIG_CW'(1);
          end
        end
        S_ROUND: begin
          ynew  <= y_sat;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            sample_out <= o_sat;
            chain      <= chain_shift;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RUN && tap == '0 && dig == '0))
    else $error("MAC loop did not start after input transfer");

  a_loop_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && tap == TAP_LAST && dig == DIG_LAST) |=> (state == S_ROUND))
    else $error("MAC loop did not end after last tap");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ready) |=> (state == S_OUT && out_valid))
    else $error("result overwrote a pending output");
`endif

endmodule

// ===== verif/iir_checker.sv =====
// Checker for the order-six IIR unit: predicts each output sample and compares transfers.
module iir_checker
  import iir6_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  output int                         err_count,
  output int                         pending
);

  localparam int ORDER = 6;
  localparam int CFRAC = 14;
  localparam int YW    = 24;
  localparam int B_TENK [0:ORDER] = '{1085, 0, -3255, 0, 3255, 0, -1085};
  localparam int A_TENK [0:ORDER] = '{10000, -11355, 9443, -6378, 5444, -1737, 459};

  longint                     b_q [0:ORDER];
  longint                     a_q [0:ORDER];
  logic signed [SAMPLE_W-1:0] x_hist [ORDER];
  logic signed [YW-1:0]       y_hist [ORDER];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic longint q_coef(input int tenk);
    longint mag;
    mag = (tenk < 0) ? -longint'(tenk) : longint'(tenk);
    mag = (mag * (longint'(1) << CFRAC) + 64'sd5000) / 64'sd10000;
    return (tenk < 0) ? -mag : mag;
  endfunction

  // round half up, then drop s fraction bits (floor)
  function automatic longint round_up_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] x
  );
    longint acc;
    longint y;
    longint o;
    acc = b_q[0] * longint'(x) * 256;
    for (int k = 1; k <= ORDER; k++) begin
      acc += b_q[k] * longint'(x_hist[k-1]) * 256;
      acc -= a_q[k] * longint'(y_hist[k-1]);
    end
    y = saturate(round_up_shift(acc, CFRAC), -(longint'(1) << (YW - 1)),
                 (longint'(1) << (YW - 1)) - 1);
    for (int k = ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = y[YW-1:0];
    o = saturate(round_up_shift(y, Y_FRAC), -32768, 32767);
    return o[SAMPLE_W-1:0];
  endfunction

  initial begin
    for (int k = 0; k <= ORDER; k++) begin
      b_q[k] = q_coef(B_TENK[k]);
      a_q[k] = q_coef(A_TENK[k]);
    end
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      expected_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          if (err_count < 10) $display("unexpected output transfer: %0d", sample_out);
          err_count <= err_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want !== sample_out) begin
            if (err_count < 10)
              $display("sample_out mismatch: expected %0d got %0d", want, sample_out);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_samples.push_back(filter_sample(sample_in));
    end
    pending <= expected_samples.size();
  end

endmodule

// ===== verif/tb_iir_direct_form_one_order6_unit.sv =====
// Testbench top for the order-six IIR unit: reset, stimulus phases and verdict.
module tb_iir_direct_form_one_order6_unit;
  import iir6_pkg::*;

  localparam int PHASE_ITEMS = 138;
  localparam int DIRECTED [23] = '{
    0, 32767, -32768, 1, -1,
    32767, 0, -32768, 0, 32767, 0, -32768, 0, 32767, 0, -32768, 0,
    -32768, -32768, -32768, 0, 0, 0
  };

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] sample_out;
  int                         err_count;
  int                         pending;
  int                         send_gap_pct = 0;
  int                         stall_pct    = 0;
  int                         tone_phase   = 0;

  always #5 clk = ~clk;

  iir_direct_form_one_order6_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out)
  );

  iir_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .err_count (err_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender off until every expected sample has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // mix of full-scale noise, small values and a quarter-rate tone that drives saturation
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    int amp;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
      4, 5, 6:    v = int'($urandom_range(511)) - 256;
      default: begin
        amp = $urandom_range(32768);
        case (tone_phase % 4)
          0:       v = amp;
          2:       v = -amp;
          default: v = int'($urandom_range(63)) - 32;
        endcase
        tone_phase++;
      end
    endcase
    if (v > 32767) v = 32767;
    return v[SAMPLE_W-1:0];
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) push_sample(DIRECTED[i][SAMPLE_W-1:0]);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 84; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 84; end
        default: begin send_gap_pct = 23; stall_pct = 23; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 60) drain();
        push_sample(pick_sample());
      end
      drain();
    end
    if (err_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
